### hw/rtl/dadc_pkg.sv
// shared constants, codes and types for the displacement abs-diff cost block
package dadc_pkg;

   // store geometry and limits
   localparam int MAX_WIDTH    = 256;
   localparam int MAX_HEIGHT   = 256;
   localparam int MAX_RADIUS   = 20;
   localparam int MAX_CHANNELS = 8;
   localparam int DEPTH        = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W       = $clog2(DEPTH);

   // field widths
   localparam int COORD_W = 8;
   localparam int SHIFT_W = 6;
   localparam int PIXEL_W = 64;
   localparam int CHAN_W  = 8;
   localparam int COST_W  = 11;
   localparam int SLOT_W  = 11;
   localparam int ERROR_W = 2;

   // register widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int DIM_W       = 9;
   localparam int RADIUS_W    = 5;
   localparam int COUNT_W     = 4;

   // register reset values
   localparam logic [DIM_W-1:0]    WIDTH_RESET  = 9'd256;
   localparam logic [DIM_W-1:0]    HEIGHT_RESET = 9'd256;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_SEARCH_RADIUS = 2'd2,
      CSR_CHANNEL_COUNT = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_MATCH = 1'b1
   } cmd_type;

   typedef enum logic [ERROR_W-1:0] {
      ERR_OK      = 2'd0,
      ERR_RANGE   = 2'd1,
      ERR_OUTSIDE = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SUM
   } state_type;

endpackage

### hw/rtl/dadc_req_if.sv
// request channel: template writes and match queries
interface dadc_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [dadc_pkg::COORD_W-1:0]        col;
   logic [dadc_pkg::COORD_W-1:0]        row;
   logic signed [dadc_pkg::SHIFT_W-1:0] shift_col;
   logic signed [dadc_pkg::SHIFT_W-1:0] shift_row;
   logic [dadc_pkg::PIXEL_W-1:0]        pixel;

   modport source (output valid, command, col, row, shift_col, shift_row, pixel,
                   input ready);
   modport sink (input valid, command, col, row, shift_col, shift_row, pixel,
                 output ready);
endinterface

### hw/rtl/dadc_rsp_if.sv
// response channel: match cost, slot and error
interface dadc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dadc_pkg::COST_W-1:0]  cost;
   logic [dadc_pkg::SLOT_W-1:0]  slot;
   logic [dadc_pkg::ERROR_W-1:0] error;

   modport source (output valid, cost, slot, error, input ready);
   modport sink (input valid, cost, slot, error, output ready);
endinterface

### hw/rtl/displacement_abs_diff_cost_top.sv
// displacement abs-diff cost: template store plus one cost-volume slot per match
//
//  channel  dir  handshake        word
//  req      in   valid/ready      command, col, row, shift_col, shift_row, pixel
//  rsp      out  valid/ready      cost, slot, error
//  csr      in   csr_we only      csr_index, csr_wdata
//
// a template write goes straight into the store at accept, so writes
// stream at one word per cycle while no match is in flight
// a match holds the input through its steps: capture at accept, checks and clamped
// store read, channel sum into the output register; the capture register and the
// registered ram read lie between accept and the sum; the result shows on rsp the
// cycle after its sum step; the output register lets a new word in while a result
// waits on rsp.ready; a second match stalls in its sum step until the register is free
// reset is synchronous and clears the fsm, the configuration registers and the output valid;
// the store is not cleared and entries never written read as garbage
module displacement_abs_diff_cost_top (
   input  logic                                  clock,
   input  logic                                  reset,
   dadc_req_if.sink                              req,
   dadc_rsp_if.source                            rsp,
   input  logic                                  csr_we,
   input  logic [dadc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dadc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // configuration registers, raw as written
   logic [dadc_pkg::DIM_W-1:0]    width_ff,  width_in;
   logic [dadc_pkg::DIM_W-1:0]    height_ff, height_in;
   logic [dadc_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [dadc_pkg::COUNT_W-1:0]  count_ff,  count_in;

   // register values saturated into their legal range
   logic [dadc_pkg::DIM_W-1:0]    w_eff;
   logic [dadc_pkg::DIM_W-1:0]    h_eff;
   logic [dadc_pkg::RADIUS_W-1:0] r_eff;
   logic [dadc_pkg::COUNT_W-1:0]  nc_eff;

   // fsm
   dadc_pkg::state_type state_ff, state_in;
   logic accept;
   logic item_load;
   logic rd_en;
   logic check_load;
   logic out_load;

   // held match word
   logic [dadc_pkg::COORD_W-1:0]        col_ff;
   logic [dadc_pkg::COORD_W-1:0]        row_ff;
   logic signed [dadc_pkg::SHIFT_W-1:0] shift_col_ff;
   logic signed [dadc_pkg::SHIFT_W-1:0] shift_row_ff;
   logic [dadc_pkg::PIXEL_W-1:0]        pixel_ff;

   // template store
   logic [dadc_pkg::PIXEL_W-1:0] store_mem [dadc_pkg::DEPTH];
   logic                         wr_en;
   logic [dadc_pkg::ADDR_W-1:0]  wr_addr;
   logic [dadc_pkg::ADDR_W-1:0]  rd_addr;
   logic [dadc_pkg::PIXEL_W-1:0] rd_data_ff;

   // lookup step
   logic signed [dadc_pkg::SHIFT_W:0]   r_s;
   logic signed [dadc_pkg::SHIFT_W:0]   dx_s;
   logic signed [dadc_pkg::SHIFT_W:0]   dy_s;
   logic                                range_bad;
   logic                                outside;
   logic signed [dadc_pkg::DIM_W:0]     x_sum;
   logic signed [dadc_pkg::DIM_W:0]     y_sum;
   logic [dadc_pkg::COORD_W-1:0]        x_clamp;
   logic [dadc_pkg::COORD_W-1:0]        y_clamp;
   logic signed [dadc_pkg::SHIFT_W:0]   dxr_s;
   logic signed [dadc_pkg::SHIFT_W:0]   dyr_s;
   logic [dadc_pkg::SHIFT_W-1:0]        span;
   logic [2*dadc_pkg::SHIFT_W-1:0]      slot_prod;
   logic [dadc_pkg::SLOT_W-1:0]         slot_calc;
   dadc_pkg::err_type                   err_calc;
   dadc_pkg::err_type                   err_ff;
   logic [dadc_pkg::SLOT_W-1:0]         slot_ff;

   // sum step
   logic [dadc_pkg::COST_W-1:0] cost_calc;

   // output register
   logic                          rsp_valid_ff,  rsp_valid_in;
   logic [dadc_pkg::COST_W-1:0]   rsp_cost_ff;
   logic [dadc_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [dadc_pkg::ERROR_W-1:0]  rsp_error_ff;

   // ---------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      count_in  = count_ff;
      if (csr_we) begin
         unique case (csr_index)
            dadc_pkg::CSR_IMAGE_WIDTH:   width_in  = csr_wdata;
            dadc_pkg::CSR_IMAGE_HEIGHT:  height_in = csr_wdata;
            dadc_pkg::CSR_SEARCH_RADIUS: radius_in = csr_wdata[dadc_pkg::RADIUS_W-1:0];
            dadc_pkg::CSR_CHANNEL_COUNT: count_in  = csr_wdata[dadc_pkg::COUNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dadc_pkg::WIDTH_RESET;
         height_ff <= dadc_pkg::HEIGHT_RESET;
         radius_ff <= dadc_pkg::RADIUS_RESET;
         count_ff  <= dadc_pkg::COUNT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
         count_ff  <= count_in;
      end
   end

   // zero counts as one, anything past the limit counts as the limit
   always_comb begin
      priority if (width_ff == '0)                 w_eff = 9'd1;
      else if (width_ff > dadc_pkg::MAX_WIDTH)     w_eff = 9'(dadc_pkg::MAX_WIDTH);
      else                                         w_eff = width_ff;

      priority if (height_ff == '0)                h_eff = 9'd1;
      else if (height_ff > dadc_pkg::MAX_HEIGHT)   h_eff = 9'(dadc_pkg::MAX_HEIGHT);
      else                                         h_eff = height_ff;

      priority if (radius_ff == '0)                r_eff = 5'd1;
      else if (radius_ff > dadc_pkg::MAX_RADIUS)   r_eff = 5'(dadc_pkg::MAX_RADIUS);
      else                                         r_eff = radius_ff;

      priority if (count_ff == '0)                 nc_eff = 4'd1;
      else if (count_ff > dadc_pkg::MAX_CHANNELS)  nc_eff = 4'(dadc_pkg::MAX_CHANNELS);
      else                                         nc_eff = count_ff;
   end

   // ---------------------------------------------------------------
   // control fsm
   // ---------------------------------------------------------------
   assign accept = req.valid && req.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dadc_pkg::ST_IDLE: begin
            if (accept && req.command == dadc_pkg::CMD_MATCH) state_in = dadc_pkg::ST_LOOKUP;
         end
         dadc_pkg::ST_LOOKUP: state_in = dadc_pkg::ST_SUM;
         dadc_pkg::ST_SUM: begin
            if (!rsp_valid_ff || rsp.ready) state_in = dadc_pkg::ST_IDLE;
         end
         default: state_in = dadc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready  = 1'b0;
      rd_en      = 1'b0;
      check_load = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         dadc_pkg::ST_IDLE:   req.ready = 1'b1;
         dadc_pkg::ST_LOOKUP: begin
            rd_en      = 1'b1;
            check_load = 1'b1;
         end
         dadc_pkg::ST_SUM:    out_load = !rsp_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   assign item_load = accept && req.command == dadc_pkg::CMD_MATCH;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dadc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_load) begin
         col_ff       <= req.col;
         row_ff       <= req.row;
         shift_col_ff <= req.shift_col;
         shift_row_ff <= req.shift_row;
         pixel_ff     <= req.pixel;
      end
   end

   // ---------------------------------------------------------------
   // template store: one write port, one registered read port
   // ---------------------------------------------------------------
   // writes land at accept; a match reads later, in its lookup step
   assign wr_en = accept && req.command == dadc_pkg::CMD_WRITE
                  && req.col < dadc_pkg::MAX_WIDTH && req.row < dadc_pkg::MAX_HEIGHT;
   assign wr_addr = dadc_pkg::ADDR_W'(req.row * dadc_pkg::MAX_WIDTH + req.col);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------
   // lookup step: window and image checks, clamped address, slot
   // ---------------------------------------------------------------
   always_comb begin
      r_s  = $signed({2'b00, r_eff});
      dx_s = {shift_col_ff[dadc_pkg::SHIFT_W-1], shift_col_ff};
      dy_s = {shift_row_ff[dadc_pkg::SHIFT_W-1], shift_row_ff};

      range_bad = (dx_s > r_s) || (dx_s < -r_s) || (dy_s > r_s) || (dy_s < -r_s);
      outside   = ({1'b0, col_ff} >= w_eff) || ({1'b0, row_ff} >= h_eff);

      // displaced position, clamped to the image edges
      x_sum = $signed({2'b00, col_ff}) + {{(dadc_pkg::DIM_W-dadc_pkg::SHIFT_W){dx_s[6]}}, dx_s};
      y_sum = $signed({2'b00, row_ff}) + {{(dadc_pkg::DIM_W-dadc_pkg::SHIFT_W){dy_s[6]}}, dy_s};

      priority if (x_sum < 0)                      x_clamp = '0;
      else if (x_sum >= $signed({1'b0, w_eff}))    x_clamp = 8'(w_eff - 9'd1);
      else                                         x_clamp = x_sum[dadc_pkg::COORD_W-1:0];

      priority if (y_sum < 0)                      y_clamp = '0;
      else if (y_sum >= $signed({1'b0, h_eff}))    y_clamp = 8'(h_eff - 9'd1);
      else                                         y_clamp = y_sum[dadc_pkg::COORD_W-1:0];

      rd_addr = dadc_pkg::ADDR_W'(y_clamp * dadc_pkg::MAX_WIDTH + x_clamp);

      // slot = (dx+r)*(2r+1) + (dy+r)
      dxr_s     = dx_s + r_s;
      dyr_s     = dy_s + r_s;
      span      = {r_eff, 1'b1};
      slot_prod = {6'b0, dxr_s[dadc_pkg::SHIFT_W-1:0]} * {6'b0, span};
      slot_calc = dadc_pkg::SLOT_W'(slot_prod + {6'b0, dyr_s[dadc_pkg::SHIFT_W-1:0]});

      priority if (range_bad) err_calc = dadc_pkg::ERR_RANGE;
      else if (outside)       err_calc = dadc_pkg::ERR_OUTSIDE;
      else                    err_calc = dadc_pkg::ERR_OK;
   end

   always_ff @(posedge clock) begin
      if (check_load) begin
         err_ff  <= err_calc;
         slot_ff <= (err_calc == dadc_pkg::ERR_OK) ? slot_calc : '0;
      end
   end

   // ---------------------------------------------------------------
   // sum step: absolute channel differences, zero on an error, over the enabled channels
   // ---------------------------------------------------------------
   always_comb begin
      logic [dadc_pkg::CHAN_W-1:0] a;
      logic [dadc_pkg::CHAN_W-1:0] b;
      cost_calc = '0;
      for (int c = 0; c < dadc_pkg::MAX_CHANNELS; c++) begin
         a = pixel_ff[c*dadc_pkg::CHAN_W +: dadc_pkg::CHAN_W];
         b = rd_data_ff[c*dadc_pkg::CHAN_W +: dadc_pkg::CHAN_W];
         if (c < nc_eff) begin
            cost_calc = cost_calc + dadc_pkg::COST_W'((a > b) ? a - b : b - a);
         end
      end
      if (err_ff != dadc_pkg::ERR_OK) cost_calc = '0;
   end

   // ---------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (out_load)  rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_cost_ff  <= cost_calc;
         rsp_slot_ff  <= slot_ff;
         rsp_error_ff <= err_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.cost  = rsp_cost_ff;
   assign rsp.slot  = rsp_slot_ff;
   assign rsp.error = rsp_error_ff;

`ifndef SYNTHESIS
   // a match always reaches the lookup step next
   assert property (@(posedge clock) disable iff (reset)
      accept && req.command == dadc_pkg::CMD_MATCH |=> state_ff == dadc_pkg::ST_LOOKUP)
      else $error("match not taken into lookup");

   // the store read is always followed by the sum step
   assert property (@(posedge clock) disable iff (reset)
      state_ff == dadc_pkg::ST_LOOKUP |=> state_ff == dadc_pkg::ST_SUM)
      else $error("lookup not followed by sum");

   // a new result appears only out of the sum step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == dadc_pkg::ST_SUM)
      else $error("result without sum step");

   // errored results carry zero cost and slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_ff != dadc_pkg::ERR_OK |-> rsp_cost_ff == '0 && rsp_slot_ff == '0)
      else $error("errored result with nonzero cost or slot");
`endif

endmodule
